[hdl/dfr_pkg.sv]
// Package for the delimited frame receiver: delimiter codes, result kinds,
// field widths and reset values shared by the RTL.
// No dependencies.
package dfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 5;
   localparam int KIND_W     = 2;

   // Default depth of the payload memory.
   localparam int DEFAULT_BUFFER_DEPTH = 32;

   // Largest value the length field can carry.
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   localparam logic [BYTE_W-1:0]  OPEN_MARK         = 8'h3C;
   localparam logic [BYTE_W-1:0]  CLOSE_MARK        = 8'h3E;
   localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RESET = 5'd31;

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO     = 2'd0,
      KIND_PAYLOAD  = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

endpackage

[hdl/delimited_frame_receiver_top.sv]
// Delimited frame receiver, top level: control, payload memory and result register.
// Depends on dfr_pkg.
//
// The block takes one received byte per req_ transaction and echoes it as
// the first rsp_ transaction. A '<' outside a frame opens a frame; bytes
// inside a frame are written to a payload memory with one write port and one
// registered read port until the limit
// (the smaller of csr max_payload and BUFFER_DEPTH - 1) is reached, and one
// byte more reports an overflow and drops the frame. A '>' inside a frame
// replays the stored bytes from the memory in order and then reports frame
// completion with its length; rsp_last marks the final result of each input
// byte. Every result passes through one output register, and the replay reads
// the memory one entry per cycle through its registered read port while
// rsp_ready does not stall that register. Input transactions are taken only
// while no replay or overflow report is in progress and the output register
// is free or being emptied. max_payload is written through csr_wr_en/csr_wr_data
// and should change only while the block is idle.
module delimited_frame_receiver_top
   import dfr_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_rx_byte,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [BYTE_W-1:0]  rsp_data,
   output logic [COUNT_W-1:0] rsp_frame_length,
   output logic               rsp_last,

   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   // Memory address width, and a width that holds both a count and an address.
   localparam int AW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int EXT_W = (AW > COUNT_W) ? AW : COUNT_W;

   // The store never holds more than BUFFER_DEPTH - 1 bytes, and the length
   // field caps the count as well.
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      COUNT_W'((BUFFER_DEPTH - 1 > COUNT_MAX) ? COUNT_MAX : BUFFER_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_OVERFLOW
   } state_type;

   state_type          state_ff, state_in;
   logic               in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [COUNT_W-1:0] max_payload_ff, max_payload_in;

   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0]  out_data_ff, out_data_in;
   logic [COUNT_W-1:0] out_len_ff, out_len_in;
   logic               out_last_ff, out_last_in;

   // Payload memory with one write port and one registered read port.
   logic [BYTE_W-1:0]  mem [BUFFER_DEPTH];
   logic [BYTE_W-1:0]  mem_q_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wr_addr;
   logic [AW-1:0]      mem_rd_addr;
   logic [EXT_W-1:0]   wr_ext;
   logic [EXT_W-1:0]   rd_ext;
   logic [COUNT_W-1:0] rd_next;

   logic               out_free;
   logic               req_accept;
   logic [COUNT_W-1:0] limit;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_valid && req_ready;
   assign limit      = (max_payload_ff > COUNT_CAP) ? COUNT_CAP : max_payload_ff;

   assign max_payload_in = csr_wr_en ? csr_wr_data : max_payload_ff;

   always_comb begin
      state_in     = state_ff;
      in_frame_in  = in_frame_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;
      mem_we       = 1'b0;
      rd_next      = COUNT_W'(0);

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // Every received byte is echoed first.
               out_valid_in = 1'b1;
               out_kind_in  = KIND_ECHO;
               out_data_in  = req_rx_byte;
               out_len_in   = COUNT_W'(0);
               out_last_in  = 1'b1;
               if (!in_frame_ff) begin
                  if (req_rx_byte == OPEN_MARK) begin
                     in_frame_in = 1'b1;
                     count_in    = COUNT_W'(0);
                  end
               end else if (req_rx_byte == CLOSE_MARK) begin
                  // Replay starts at entry zero, which the read port fetches
                  // at this same edge.
                  in_frame_in = 1'b0;
                  rd_idx_in   = COUNT_W'(0);
                  out_last_in = 1'b0;
                  state_in    = ST_DRAIN;
               end else if (count_ff < limit) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  in_frame_in = 1'b0;
                  count_in    = COUNT_W'(0);
                  out_last_in = 1'b0;
                  state_in    = ST_OVERFLOW;
               end
            end
         end

         ST_DRAIN: begin
            rd_next = rd_idx_ff;
            if (out_free) begin
               out_valid_in = 1'b1;
               if (rd_idx_ff == count_ff) begin
                  out_kind_in = KIND_COMPLETE;
                  out_data_in = '0;
                  out_len_in  = count_ff;
                  out_last_in = 1'b1;
                  count_in    = COUNT_W'(0);
                  state_in    = ST_IDLE;
               end else begin
                  // The read register holds the entry at rd_idx_ff; fetch the
                  // following one for the next cycle.
                  out_kind_in = KIND_PAYLOAD;
                  out_data_in = mem_q_ff;
                  out_len_in  = COUNT_W'(0);
                  out_last_in = 1'b0;
                  rd_next     = rd_idx_ff + COUNT_W'(1);
                  rd_idx_in   = rd_next;
               end
            end
         end

         ST_OVERFLOW: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_OVERFLOW;
               out_data_in  = '0;
               out_len_in   = COUNT_W'(0);
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_ext      = EXT_W'(count_ff);
   assign mem_wr_addr = wr_ext[AW-1:0];
   assign rd_ext      = EXT_W'(rd_next);
   assign mem_rd_addr = rd_ext[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= req_rx_byte;
      end
      mem_q_ff <= mem[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         in_frame_ff    <= 1'b0;
         count_ff       <= COUNT_W'(0);
         rd_idx_ff      <= COUNT_W'(0);
         max_payload_ff <= MAX_PAYLOAD_RESET;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         in_frame_ff    <= in_frame_in;
         count_ff       <= count_in;
         rd_idx_ff      <= rd_idx_in;
         max_payload_ff <= max_payload_in;
         out_valid_ff   <= out_valid_in;
      end
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_len_ff  <= out_len_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_data         = out_data_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_last         = out_last_ff;

   // The stored count never passes what the memory can hold.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_CAP)
      else $error("stored count exceeds memory capacity");

   // The replay pointer never runs past the stored count.
   a_drain_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (rd_idx_ff <= count_ff))
      else $error("replay index beyond stored count");

   // A closing byte inside a frame starts a replay and closes the frame.
   a_close_drain: assert property (@(posedge clock) disable iff (reset)
      (req_accept && in_frame_ff && (req_rx_byte == CLOSE_MARK))
      |=> (state_ff == ST_DRAIN) && !in_frame_ff)
      else $error("close delimiter did not start replay");

   // No frame is open while a replay or overflow report is pending.
   a_busy_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !in_frame_ff)
      else $error("frame open during replay or overflow");

   // A payload byte is never the final result of its input byte.
   a_payload_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == KIND_PAYLOAD)) |-> !out_last_ff)
      else $error("payload result marked last");

endmodule

[sim/tb_top.sv]
// Testbench for the delimited frame receiver: directed frame cases, then random frame traffic.
// Depends on dfr_pkg and delimited_frame_receiver_top. It needs no other file.
module tb_top
   import dfr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The payload memory keeps its default depth, so the limit register can never reach
   // past the memory and the effective limit is simply max_payload.
   localparam int STORE_DEPTH = DEFAULT_BUFFER_DEPTH;

   // The bound covers every byte closing a full frame with every result stalled
   // for the longest burst.
   localparam int CYCLE_LIMIT = 1_000_000;

   // One result as the block should present it.
   typedef struct {
      kind_type           kind;
      logic [BYTE_W-1:0]  data;
      logic [COUNT_W-1:0] frame_length;
      logic               last;
   } rx_output_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [BYTE_W-1:0]  req_rx_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   logic [KIND_W-1:0]  rsp_kind;
   logic [BYTE_W-1:0]  rsp_data;
   logic [COUNT_W-1:0] rsp_frame_length;
   logic               rsp_last;
   logic               csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   // Results that the block still owes, oldest first.
   rx_output_type rx_outputs_due[$];

   // Our own copy of the receiver state and of the limit register.
   logic               frame_open = 1'b0;
   int                 bytes_held = 0;
   logic [BYTE_W-1:0]  held_bytes [STORE_DEPTH];
   logic [COUNT_W-1:0] payload_limit = MAX_PAYLOAD_RESET;

   // While this is set, both the sender and the receiver insert random idle bursts.
   bit traffic_gaps_on = 1'b1;

   int mismatch_count = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int limit_writes = 0;
   int overflows_seen = 0;
   int longest_frame = 0;
   int cycle_count = 0;

   delimited_frame_receiver_top #(
      .BUFFER_DEPTH(STORE_DEPTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_frame_length(rsp_frame_length),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog. If the run has not ended by the limit, something hung.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Works out every result that one received byte causes and queues them in order.
   // The echo always comes first; the final result of the byte carries last.
   task automatic parse_rx_byte(input logic [BYTE_W-1:0] rx);
      rx_output_type outs[$];
      int            eff_limit;
      int            k;
      eff_limit = (payload_limit > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : payload_limit;
      outs.push_back('{KIND_ECHO, rx, '0, 1'b0});
      if (!frame_open) begin
         if (rx == OPEN_MARK) begin
            frame_open = 1'b1;
            bytes_held = 0;
         end
      end else if (rx == CLOSE_MARK) begin
         for (k = 0; k < bytes_held; k++) begin
            outs.push_back('{KIND_PAYLOAD, held_bytes[k], '0, 1'b0});
         end
         outs.push_back('{KIND_COMPLETE, '0, COUNT_W'(bytes_held), 1'b0});
         if (bytes_held > longest_frame) begin
            longest_frame = bytes_held;
         end
         frame_open = 1'b0;
         bytes_held = 0;
      end else if (bytes_held < eff_limit) begin
         held_bytes[bytes_held] = rx;
         bytes_held++;
      end else begin
         outs.push_back('{KIND_OVERFLOW, '0, '0, 1'b0});
         overflows_seen++;
         frame_open = 1'b0;
         bytes_held = 0;
      end
      outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) begin
         rx_outputs_due.push_back(outs[i]);
      end
   endtask

   // Sends one byte. It is called at a rising edge and returns at the edge where the
   // transaction was accepted, with req_valid still high so back-to-back bytes need
   // no extra assignment.
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      if (traffic_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do begin
         @(posedge clock);
      end while (!req_ready);
      parse_rx_byte(rx);
      bytes_sent++;
   endtask

   // Stops sending and waits until every owed result has come out, then lets the
   // block sit idle as extra_cycles asks.
   task automatic settle_block(input int extra_cycles);
      req_valid <= 1'b0;
      while (rx_outputs_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (extra_cycles) @(posedge clock);
   endtask

   // The limit register is only written while the block is idle.
   task automatic write_payload_limit(input logic [COUNT_W-1:0] value);
      settle_block(4);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      payload_limit = value;
      limit_writes++;
   endtask

   // Random payload content. A closer would end the frame early, so it is swapped for
   // an opener, which inside a frame is ordinary payload.
   function automatic logic [BYTE_W-1:0] payload_byte();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(0, 255));
      if (b == CLOSE_MARK) begin
         b = OPEN_MARK;
      end
      return b;
   endfunction

   // Bytes outside a frame, a closer among them, are only echoed.
   task automatic test_echo_outside_frame();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CLOSE_MARK);
   endtask

   // An opener directly followed by a closer gives a complete item of length zero.
   task automatic test_empty_frame();
      send_byte(OPEN_MARK);
      send_byte(CLOSE_MARK);
   endtask

   // A second opener and the zero byte inside a frame are both stored as payload.
   task automatic test_opener_and_zero_inside();
      send_byte(OPEN_MARK);
      send_byte(OPEN_MARK);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CLOSE_MARK);
   endtask

   // With a limit of zero, the very first payload byte overflows and drops the frame.
   task automatic test_zero_limit();
      write_payload_limit(5'd0);
      send_byte(OPEN_MARK);
      send_byte(8'h41);
      send_byte(8'h5A);
   endtask

   // One byte past the limit overflows; the closer that follows is then outside a frame.
   task automatic test_overflow();
      write_payload_limit(5'd2);
      send_byte(OPEN_MARK);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_byte(8'h80);
      send_byte(CLOSE_MARK);
   endtask

   // A frame filled exactly to the limit still completes normally.
   task automatic test_frame_at_limit();
      write_payload_limit(5'd3);
      send_byte(OPEN_MARK);
      send_byte(8'h01);
      send_byte(8'h7F);
      send_byte(8'hFE);
      send_byte(CLOSE_MARK);
   endtask

   // Random traffic under one limit setting. Most of it is well-formed frames of random
   // length and content, including frames exactly at the limit and one byte past it.
   // The rest is line noise between frames and frames that are never closed.
   task automatic test_random_frames(input logic [COUNT_W-1:0] limit, input int budget);
      int start_count;
      int shape;
      int payload_len;
      int n;
      write_payload_limit(limit);
      start_count = bytes_sent;
      while (bytes_sent - start_count < budget) begin
         shape = $urandom_range(0, 9);
         if (shape == 0) begin
            // Noise on the line; an occasional opener here starts a frame by accident.
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
         end else if (shape == 1) begin
            // A frame that is abandoned without a closer.
            send_byte(OPEN_MARK);
            repeat ($urandom_range(0, 3)) send_byte(payload_byte());
         end else begin
            case ($urandom_range(0, 7))
               0:       payload_len = limit;
               1:       payload_len = limit + 1;
               2:       payload_len = 0;
               default: payload_len = $urandom_range(0, limit);
            endcase
            send_byte(OPEN_MARK);
            for (n = 0; n < payload_len; n++) begin
               send_byte(payload_byte());
            end
            send_byte(CLOSE_MARK);
         end
      end
   endtask

   // The receiver side stalls in random bursts while gaps are enabled.
   initial begin
      forever begin
         @(posedge clock);
         if (traffic_gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Every result transaction is compared field by field with the oldest owed result.
   always @(posedge clock) begin
      rx_output_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rx_outputs_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing owed: kind %0d data %02h",
                                      rsp_kind, rsp_data));
         end else begin
            want = rx_outputs_due.pop_front();
            if (rsp_kind !== want.kind) begin
               report_mismatch($sformatf("kind %0d, owed %0d", rsp_kind, want.kind));
            end
            if (rsp_data !== want.data) begin
               report_mismatch($sformatf("data %02h, owed %02h", rsp_data, want.data));
            end
            if (rsp_frame_length !== want.frame_length) begin
               report_mismatch($sformatf("frame_length %0d, owed %0d",
                                         rsp_frame_length, want.frame_length));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("last %0b, owed %0b", rsp_last, want.last));
            end
         end
      end
   end

   initial begin
      // Synchronous reset is held at the start; the predictor already holds reset state.
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases, starting under the reset value of the limit.
      test_echo_outside_frame();
      test_empty_frame();
      test_opener_and_zero_inside();
      test_zero_limit();
      test_overflow();
      test_frame_at_limit();

      // Random traffic across several limits, the extremes included.
      test_random_frames(5'd31, 36);
      test_random_frames(5'd0, 35);
      test_random_frames(5'd1, 35);
      test_random_frames(5'd7, 38);
      test_random_frames(5'd30, 36);
      test_random_frames(COUNT_W'($urandom_range(2, 29)), 38);

      // The last stretch runs with no idling on either side.
      settle_block(4);
      traffic_gaps_on = 1'b0;
      test_random_frames(5'd31, 36);

      // Wait out the longest replay after the last owed result.
      settle_block(40);
      if (rx_outputs_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", rx_outputs_due.size()));
      end

      $display("Run covered %0d received bytes and %0d checked results over %0d limit writes.",
               bytes_sent, results_seen, limit_writes);
      $display("Frames ran up to %0d payload bytes; %0d frames were dropped on overflow.",
               longest_frame, overflows_seen);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/dfr_pkg.sv
hdl/delimited_frame_receiver_top.sv
sim/tb_top.sv
